FILE: design/lsq_pkg.sv
// Shared types and constants for the least-squares line fit block.
// No dependencies; imported by every module of the block.
`default_nettype none

package lsq_pkg;

  localparam int COORD_W    = 16;
  localparam int FRAC_BITS  = COORD_W / 2;
  localparam int MAX_POINTS = 1024;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  // exact running sums
  localparam int SUM_W = COORD_W + CNT_W;
  localparam int XY_W  = 2 * COORD_W + CNT_W - 1;
  localparam int XX_W  = 2 * COORD_W + CNT_W - 2;

  // datapath of the shared adder: holds the scaled intercept numerator plus margin
  localparam int FIT_W     = 80;
  localparam int MUL_STEPS = SUM_W;
  localparam int Q_W       = 33;
  localparam int STEP_W    = 6;
  localparam int RES_W     = 32;

  localparam int SLOPE_SHIFT = 16;
  localparam int ICPT_SHIFT  = 16 - FRAC_BITS;

  localparam logic [Q_W-1:0]   Q_LIM_POS = 33'h0_7FFF_FFFF;
  localparam logic [Q_W-1:0]   Q_LIM_NEG = 33'h0_8000_0000;
  localparam logic [RES_W-1:0] RES_MAX   = 32'h7FFF_FFFF;
  localparam logic [RES_W-1:0] RES_MIN   = 32'h8000_0000;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FLAT = 2'd1,
    ST_MANY = 2'd2,
    ST_SAT  = 2'd3
  } status_t;

  typedef struct packed {
    logic [CNT_W-1:0]        cnt;
    logic signed [SUM_W-1:0] sx;
    logic signed [SUM_W-1:0] sy;
    logic signed [XY_W-1:0]  sxy;
    logic [XX_W-1:0]         sxx;
    logic                    overflow;
  } sums_t;

  typedef struct packed {
    logic signed [RES_W-1:0] slope;
    logic signed [RES_W-1:0] intercept;
    status_t                 status;
    logic [CNT_W-1:0]        count;
  } fit_res_t;

endpackage

`default_nettype wire

FILE: design/lsq_accum.sv
// Point accumulator: registers x*y and x*x, then adds them into the exact sums.
// Depends on lsq_pkg.
`default_nettype none

module lsq_accum
  import lsq_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      take,
  input  wire logic signed [COORD_W-1:0] x,
  input  wire logic signed [COORD_W-1:0] y,
  input  wire logic                      last,
  input  wire logic                      clear,
  output sums_t                          sums,
  output logic                           pend,
  output logic                           fit_start
);

  logic signed [COORD_W-1:0]   x_r;
  logic signed [COORD_W-1:0]   y_r;
  logic signed [2*COORD_W-1:0] xy_prod;
  logic signed [2*COORD_W-1:0] xx_prod;
  logic                        pend_last;
  logic                        pend_use;
  logic                        room;

  assign room      = sums.cnt < CNT_W'(MAX_POINTS);
  assign fit_start = pend & pend_last;

  always_ff @(posedge clk) begin
    if (take) begin
      x_r     <= x;
      y_r     <= y;
      xy_prod <= x * y;
      xx_prod <= x * x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      pend_last <= 1'b0;
      pend_use  <= 1'b0;
    end else begin
      pend <= take;
      if (take) begin
        pend_last <= last;
        pend_use  <= room;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      sums <= '0;
    end else begin
      // drop points beyond the limit, but remember that they came
      if (take && !room) begin
        sums.overflow <= 1'b1;
      end
      if (pend && pend_use) begin
        sums.cnt <= sums.cnt + CNT_W'(1);
        sums.sx  <= sums.sx + SUM_W'(x_r);
        sums.sy  <= sums.sy + SUM_W'(y_r);
        sums.sxy <= sums.sxy + XY_W'(xy_prod);
        sums.sxx <= sums.sxx + XX_W'($unsigned(xx_prod));
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/lsq_alu.sv
// Shared add/subtract unit of the fit sequencer, also used as a compare.
// Depends on lsq_pkg.
`default_nettype none

module lsq_alu
  import lsq_pkg::*;
(
  input  wire logic [FIT_W-1:0] a,
  input  wire logic [FIT_W-1:0] b,
  input  wire logic             sub,
  output logic [FIT_W-1:0]      sum,
  output logic                  non_neg
);

  assign sum     = a + (sub ? ~b : b) + FIT_W'(sub);
  assign non_neg = ~sum[FIT_W-1];

endmodule

`default_nettype wire

FILE: design/lsq_fit.sv
// Fit sequencer: shift-add products and restoring divides on one shared adder.
// Depends on lsq_pkg and lsq_alu.
`default_nettype none

module lsq_fit
  import lsq_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  input  wire sums_t sums,
  input  wire logic  res_free,
  output logic       busy,
  output logic       done,
  output fit_res_t   res
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_LOAD  = 9'b000000010,
    S_MUL   = 9'b000000100,
    S_MAG   = 9'b000001000,
    S_ADDN  = 9'b000010000,
    S_CHK   = 9'b000100000,
    S_DIV   = 9'b001000000,
    S_QOUT  = 9'b010000000,
    S_FINAL = 9'b100000000
  } state_t;

  // product order; odd entries are subtracted from the running value
  localparam logic [2:0] P_NSXX  = 3'd0;
  localparam logic [2:0] P_SXSX  = 3'd1;
  localparam logic [2:0] P_NSXY  = 3'd2;
  localparam logic [2:0] P_SXSY  = 3'd3;
  localparam logic [2:0] P_SXXSY = 3'd4;
  localparam logic [2:0] P_SXYSX = 3'd5;

  state_t            state;
  logic [2:0]        prod;
  logic [STEP_W-1:0] step;
  logic [FIT_W-1:0]  acc;
  logic [FIT_W-1:0]  mcand;
  logic [SUM_W-1:0]  mplier;
  logic [FIT_W-1:0]  den;
  logic [FIT_W-1:0]  rem;
  logic [Q_W-1:0]    quo;
  logic              neg;
  logic              sat;
  logic              flat;
  logic [RES_W-1:0]  slope_r;
  logic [RES_W-1:0]  icpt_r;

  logic [FIT_W-1:0]  sel_mc;
  logic [SUM_W-1:0]  sel_mp;
  logic [FIT_W-1:0]  alu_a;
  logic [FIT_W-1:0]  alu_b;
  logic              alu_sub;
  logic [FIT_W-1:0]  alu_sum;
  logic              ge;
  logic              too_big;
  logic [RES_W-1:0]  qval;
  logic [FIT_W-1:0]  sx_ext;
  logic [FIT_W-1:0]  sxy_ext;
  logic [FIT_W-1:0]  sxx_ext;
  logic [SUM_W-1:0]  sx_mp;
  logic [SUM_W-1:0]  sy_mp;
  logic [SUM_W-1:0]  n_mp;

  assign sx_ext  = {{(FIT_W-SUM_W){sums.sx[SUM_W-1]}}, sums.sx};
  assign sxy_ext = {{(FIT_W-XY_W){sums.sxy[XY_W-1]}}, sums.sxy};
  assign sxx_ext = FIT_W'(sums.sxx);
  assign sx_mp   = sums.sx;
  assign sy_mp   = sums.sy;
  assign n_mp    = SUM_W'(sums.cnt);

  always_comb begin
    case (prod)
      P_NSXX:  begin sel_mc = sxx_ext; sel_mp = n_mp;  end
      P_SXSX:  begin sel_mc = sx_ext;  sel_mp = sx_mp; end
      P_NSXY:  begin sel_mc = sxy_ext; sel_mp = n_mp;  end
      P_SXSY:  begin sel_mc = sx_ext;  sel_mp = sy_mp; end
      P_SXXSY: begin sel_mc = sxx_ext; sel_mp = sy_mp; end
      P_SXYSX: begin sel_mc = sxy_ext; sel_mp = sx_mp; end
      default: begin sel_mc = '0;      sel_mp = '0;    end
    endcase
  end

  always_comb begin
    alu_a   = acc;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state)
      S_MUL: begin
        alu_b   = mplier[0] ? mcand : '0;
        // the multiplier's top bit carries negative weight
        alu_sub = prod[0] ^ (step == STEP_W'(MUL_STEPS - 1));
      end
      S_MAG: begin
        alu_a   = acc[FIT_W-1] ? '0 : acc;
        alu_b   = acc[FIT_W-1] ? acc : '0;
        alu_sub = acc[FIT_W-1];
      end
      S_ADDN: begin
        // dividend 2*(|num| << s) + den gives round-half-away on division by 2*den
        alu_a = (prod == P_SXSY) ? (acc << (SLOPE_SHIFT + 1)) : (acc << (ICPT_SHIFT + 1));
        alu_b = den;
      end
      S_CHK: begin
        alu_a   = acc >> Q_W;
        alu_b   = den << 1;
        alu_sub = 1'b1;
      end
      S_DIV: begin
        alu_a   = {rem[FIT_W-2:0], acc[Q_W-1]};
        alu_b   = den << 1;
        alu_sub = 1'b1;
      end
      default: begin
        alu_a = acc;
      end
    endcase
  end

  lsq_alu u_alu (
    .a       (alu_a),
    .b       (alu_b),
    .sub     (alu_sub),
    .sum     (alu_sum),
    .non_neg (ge)
  );

  always_comb begin
    too_big = neg ? (quo > Q_LIM_NEG) : (quo > Q_LIM_POS);
    if (too_big) begin
      qval = neg ? RES_MIN : RES_MAX;
    end else begin
      qval = neg ? (~quo[RES_W-1:0] + RES_W'(1)) : quo[RES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            prod    <= P_NSXX;
            sat     <= 1'b0;
            flat    <= 1'b0;
            slope_r <= '0;
            icpt_r  <= '0;
            state   <= S_LOAD;
          end
        end
        S_LOAD: begin
          mcand  <= sel_mc;
          mplier <= sel_mp;
          step   <= '0;
          if (!prod[0]) begin
            acc <= '0;
          end
          state <= S_MUL;
        end
        S_MUL: begin
          acc    <= alu_sum;
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          step   <= step + STEP_W'(1);
          if (step == STEP_W'(MUL_STEPS - 1)) begin
            case (prod)
              P_SXSX: begin
                if (alu_sum[FIT_W-1] || alu_sum == '0) begin
                  flat  <= 1'b1;
                  state <= S_FINAL;
                end else begin
                  den   <= alu_sum;
                  prod  <= P_NSXY;
                  state <= S_LOAD;
                end
              end
              P_SXSY, P_SXYSX: begin
                state <= S_MAG;
              end
              default: begin
                prod  <= prod + 3'd1;
                state <= S_LOAD;
              end
            endcase
          end
        end
        S_MAG: begin
          neg   <= acc[FIT_W-1];
          acc   <= alu_sum;
          state <= S_ADDN;
        end
        S_ADDN: begin
          acc   <= alu_sum;
          state <= S_CHK;
        end
        S_CHK: begin
          if (ge) begin
            // quotient would not fit: force a saturated value
            quo   <= '1;
            state <= S_QOUT;
          end else begin
            rem   <= acc >> Q_W;
            quo   <= '0;
            step  <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem  <= ge ? alu_sum : {rem[FIT_W-2:0], acc[Q_W-1]};
          quo  <= {quo[Q_W-2:0], ge};
          acc  <= acc << 1;
          step <= step + STEP_W'(1);
          if (step == STEP_W'(Q_W - 1)) begin
            state <= S_QOUT;
          end
        end
        S_QOUT: begin
          sat <= sat | too_big;
          if (prod == P_SXSY) begin
            slope_r <= qval;
            prod    <= P_SXXSY;
            state   <= S_LOAD;
          end else begin
            icpt_r <= qval;
            state  <= S_FINAL;
          end
        end
        S_FINAL: begin
          if (res_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_FINAL) && res_free;

  always_comb begin
    res.slope     = slope_r;
    res.intercept = icpt_r;
    res.count     = sums.cnt;
    if (flat) begin
      res.status = ST_FLAT;
    end else if (sums.overflow) begin
      res.status = ST_MANY;
    end else if (sat) begin
      res.status = ST_SAT;
    end else begin
      res.status = ST_OK;
    end
  end

endmodule

`default_nettype wire

FILE: design/least_squares_line_fit.sv
// Least-squares line fit: an ordinary point is multiplied into a register and then
// added into the sums before the next point is taken; the point marked last then holds
// the input while the fit sequencer runs six 27-step shift-add products and two
// 33-step divides on one shared 80-bit adder (two products if the x spread is zero).
// The result sits in an output register; new points are taken while it waits.
// Synchronous reset clears the sums, the sequencer and the output valid.
`default_nettype none

module least_squares_line_fit
  import lsq_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      point_valid,
  output logic                           point_ready,
  input  wire logic signed [COORD_W-1:0] point_x,
  input  wire logic signed [COORD_W-1:0] point_y,
  input  wire logic                      last_point,
  output logic                           fit_valid,
  input  wire logic                      fit_ready,
  output logic signed [RES_W-1:0]        slope,
  output logic signed [RES_W-1:0]        intercept,
  output logic [1:0]                     fit_status,
  output logic [CNT_W-1:0]               point_count
);

  sums_t    sums;
  fit_res_t res;
  fit_res_t out_r;
  logic     pend;
  logic     fit_start;
  logic     fit_busy;
  logic     fit_done;
  logic     res_free;
  logic     take;

  assign point_ready = ~pend & ~fit_busy;
  assign take        = point_valid & point_ready;
  assign res_free    = ~fit_valid | fit_ready;

  lsq_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .x         (point_x),
    .y         (point_y),
    .last      (last_point),
    .clear     (fit_done),
    .sums      (sums),
    .pend      (pend),
    .fit_start (fit_start)
  );

  lsq_fit u_fit (
    .clk      (clk),
    .rst      (rst),
    .start    (fit_start),
    .sums     (sums),
    .res_free (res_free),
    .busy     (fit_busy),
    .done     (fit_done),
    .res      (res)
  );

  // hold the result beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_valid <= 1'b0;
    end else if (fit_done) begin
      fit_valid <= 1'b1;
    end else if (fit_ready) begin
      fit_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fit_done) begin
      out_r <= res;
    end
  end

  assign slope       = out_r.slope;
  assign intercept   = out_r.intercept;
  assign fit_status  = out_r.status;
  assign point_count = out_r.count;

endmodule

`default_nettype wire
